// File: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants and types for the linear-probing hash table: opcodes,
// status codes, slot marks, stream packing widths and the control structs.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Default table size (power of two, 8 to 65536)
  localparam int unsigned DEF_TABLE_SLOTS = 256;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned MARK_W   = 2;

  // Stream data widths, rounded up to whole bytes
  localparam int unsigned IN_BITS     = OP_W + 3 * WORD_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = STATUS_W + WORD_W + COUNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Opcodes
  localparam logic [OP_W-1:0] OP_GET = 2'd0;
  localparam logic [OP_W-1:0] OP_SET = 2'd1;
  localparam logic [OP_W-1:0] OP_POP = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Slot marks
  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

  // Write enables into the slot store
  typedef struct packed {
    logic mark;
    logic entry;   // hash and key
    logic value;
  } wr_en_t;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   value;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

// File: rtl/lpht_store.sv
// ----------------------------------------------------------------------------
// lpht_store
// Slot storage: mark, hash/key and value memories. One write port and one
// registered read port, all three read together at the same slot.
// ----------------------------------------------------------------------------
module lpht_store #(
  parameter int unsigned TABLE_SLOTS = lpht_pkg::DEF_TABLE_SLOTS,
  localparam int unsigned IDX_W      = $clog2(TABLE_SLOTS)
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [IDX_W-1:0]              rd_addr,
  input  lpht_pkg::wr_en_t              wr,
  input  logic [IDX_W-1:0]              wr_addr,
  input  logic [lpht_pkg::MARK_W-1:0]   wr_mark,
  input  logic [lpht_pkg::WORD_W-1:0]   wr_hash,
  input  logic [lpht_pkg::WORD_W-1:0]   wr_key,
  input  logic [lpht_pkg::WORD_W-1:0]   wr_value,
  output logic [lpht_pkg::MARK_W-1:0]   rd_mark,
  output logic [lpht_pkg::WORD_W-1:0]   rd_hash,
  output logic [lpht_pkg::WORD_W-1:0]   rd_key,
  output logic [lpht_pkg::WORD_W-1:0]   rd_value
);
  import lpht_pkg::*;

  logic [MARK_W-1:0]   mark_mem  [TABLE_SLOTS];
  logic [2*WORD_W-1:0] entry_mem [TABLE_SLOTS];
  logic [WORD_W-1:0]   value_mem [TABLE_SLOTS];

  logic [MARK_W-1:0]   mark_r;
  logic [2*WORD_W-1:0] entry_r;
  logic [WORD_W-1:0]   value_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.mark) begin
      mark_mem[wr_addr] <= wr_mark;
    end
    if (wr.entry) begin
      entry_mem[wr_addr] <= {wr_hash, wr_key};
    end
    if (wr.value) begin
      value_mem[wr_addr] <= wr_value;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mark_r  <= mark_mem[rd_addr];
      entry_r <= entry_mem[rd_addr];
      value_r <= value_mem[rd_addr];
    end
  end

  assign rd_mark  = mark_r;
  assign rd_hash  = entry_r[2*WORD_W-1:WORD_W];
  assign rd_key   = entry_r[WORD_W-1:0];
  assign rd_value = value_r;

endmodule

// File: rtl/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Probe sequencer. Clears the mark memory after reset, then walks the table
// one slot per cycle through a single compare unit, issuing the next slot's
// read while the current slot is compared, and applies the update.
// ----------------------------------------------------------------------------
module lpht_ctrl #(
  parameter int unsigned TABLE_SLOTS = lpht_pkg::DEF_TABLE_SLOTS,
  localparam int unsigned IDX_W      = $clog2(TABLE_SLOTS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [lpht_pkg::OP_W-1:0]     req_op,
  input  logic [lpht_pkg::WORD_W-1:0]   req_key,
  input  logic [lpht_pkg::WORD_W-1:0]   req_hash,
  input  logic [lpht_pkg::WORD_W-1:0]   req_wval,
  // result
  output lpht_pkg::res_t                res,
  input  logic                          res_take,
  // store
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  output lpht_pkg::wr_en_t              wr,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [lpht_pkg::MARK_W-1:0]   wr_mark,
  output logic [lpht_pkg::WORD_W-1:0]   wr_hash,
  output logic [lpht_pkg::WORD_W-1:0]   wr_key,
  output logic [lpht_pkg::WORD_W-1:0]   wr_value,
  input  logic [lpht_pkg::MARK_W-1:0]   rd_mark,
  input  logic [lpht_pkg::WORD_W-1:0]   rd_hash,
  input  logic [lpht_pkg::WORD_W-1:0]   rd_key,
  input  logic [lpht_pkg::WORD_W-1:0]   rd_value
);
  import lpht_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PROBE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;      // slot whose data is being compared
  logic [IDX_W-1:0]    visit_r, visit_nxt;    // slots compared so far
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [WORD_W-1:0]   key_r, key_nxt;
  logic [WORD_W-1:0]   hash_r, hash_nxt;
  logic [WORD_W-1:0]   wval_r, wval_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [WORD_W-1:0]   value_r, value_nxt;

  logic                match;
  logic                req_known;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  // Shared compare unit
  assign match     = (rd_mark == MARK_LIVE) && (rd_hash == hash_r) && (rd_key == key_r);
  assign req_known = (req_op == OP_GET) || (req_op == OP_SET) || (req_op == OP_POP);

  // Count is reported masked to the output width
  assign count_ext = {{COUNT_W{1'b0}}, count_r};

  assign req_ready  = (state_r == S_IDLE);
  assign res.valid  = (state_r == S_DONE);
  assign res.status = status_r;
  assign res.value  = value_r;
  assign res.count  = count_ext[COUNT_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    slot_nxt   = slot_r;
    visit_nxt  = visit_r;
    count_nxt  = count_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    hash_nxt   = hash_r;
    wval_nxt   = wval_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    rd_en      = 1'b0;
    rd_addr    = slot_r + IDX_W'(1);
    wr         = '0;
    wr_addr    = slot_r;
    wr_mark    = MARK_LIVE;
    wr_hash    = hash_r;
    wr_key     = key_r;
    wr_value   = wval_r;

    case (state_r)
      S_CLEAR: begin
        wr.mark = 1'b1;
        wr_addr = clr_r;
        wr_mark = MARK_EMPTY;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          op_nxt     = req_op;
          key_nxt    = req_key;
          hash_nxt   = req_hash;
          wval_nxt   = req_wval;
          status_nxt = ST_OK;
          value_nxt  = '0;
          if (req_known) begin
            rd_en     = 1'b1;
            rd_addr   = req_hash[IDX_W-1:0];
            slot_nxt  = req_hash[IDX_W-1:0];
            visit_nxt = '0;
            state_nxt = S_PROBE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_PROBE: begin
        // fetch the following slot speculatively
        rd_en     = 1'b1;
        slot_nxt  = slot_r + IDX_W'(1);
        visit_nxt = visit_r + IDX_W'(1);
        if (rd_mark == MARK_EMPTY) begin
          state_nxt = S_DONE;
          if (op_r == OP_SET) begin
            wr.mark   = 1'b1;
            wr.entry  = 1'b1;
            wr.value  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            status_nxt = ST_MISSING;
          end
        end else if (match) begin
          state_nxt = S_DONE;
          if (op_r == OP_SET) begin
            wr.value = 1'b1;
          end else begin
            value_nxt = rd_value;
            if (op_r == OP_POP) begin
              wr.mark = 1'b1;
              wr_mark = MARK_TOMB;
              if (count_r != '0) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
          end
        end else if (visit_r == '1) begin
          // full wrap without a match or an empty slot
          state_nxt  = S_DONE;
          status_nxt = (op_r == OP_SET) ? ST_FULL : ST_MISSING;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    visit_r  <= visit_nxt;
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    hash_r   <= hash_nxt;
    wval_r   <= wval_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
  end

endmodule

// File: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing: get, set and pop.
//
// Usage:
//   Requests arrive on the in_ stream (opcode, key, precomputed hash, value),
//   one result per request leaves on the out_ stream (status, value read,
//   live entry count). Transfers complete when tvalid and tready are high.
//   The probe starts at hash AND (TABLE_SLOTS-1) and visits one slot per
//   cycle through a single compare unit fed by the registered memory read.
//   A request visits 1 to TABLE_SLOTS slots (opcode 3 visits none); its
//   result goes from the sequencer into the output register, and only then
//   is the next request taken.
//   After reset the mark memory is cleared one slot per cycle; in_tready
//   stays low until every slot is cleared. A result waiting in the output
//   register does not stop the next request from being taken; the sequencer
//   only waits at the end of that request if the register is still full.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int unsigned TABLE_SLOTS = lpht_pkg::DEF_TABLE_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lpht_pkg::IN_TDATA_W-1:0]     in_tdata,   // opcode, key_word, key_hash, write_value
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lpht_pkg::OUT_TDATA_W-1:0]    out_tdata   // status, read_value, entry_count
);
  import lpht_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);

  logic [OP_W-1:0]     in_op;
  logic [WORD_W-1:0]   in_key;
  logic [WORD_W-1:0]   in_hash;
  logic [WORD_W-1:0]   in_wval;

  res_t                res;
  logic                res_take;

  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  wr_en_t              wr;
  logic [IDX_W-1:0]    wr_addr;
  logic [MARK_W-1:0]   wr_mark;
  logic [WORD_W-1:0]   wr_hash;
  logic [WORD_W-1:0]   wr_key;
  logic [WORD_W-1:0]   wr_value;
  logic [MARK_W-1:0]   rd_mark;
  logic [WORD_W-1:0]   rd_hash;
  logic [WORD_W-1:0]   rd_key;
  logic [WORD_W-1:0]   rd_value;

  logic                out_valid_r;
  logic [OUT_BITS-1:0] out_data_r;

  // Unpack request
  assign in_op   = in_tdata[OP_W-1:0];
  assign in_key  = in_tdata[OP_W +: WORD_W];
  assign in_hash = in_tdata[OP_W+WORD_W +: WORD_W];
  assign in_wval = in_tdata[OP_W+2*WORD_W +: WORD_W];

  lpht_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_op    (in_op),
    .req_key   (in_key),
    .req_hash  (in_hash),
    .req_wval  (in_wval),
    .res       (res),
    .res_take  (res_take),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .wr_mark   (wr_mark),
    .wr_hash   (wr_hash),
    .wr_key    (wr_key),
    .wr_value  (wr_value),
    .rd_mark   (rd_mark),
    .rd_hash   (rd_hash),
    .rd_key    (rd_key),
    .rd_value  (rd_value)
  );

  lpht_store #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_store (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .wr_mark  (wr_mark),
    .wr_hash  (wr_hash),
    .wr_key   (wr_key),
    .wr_value (wr_value),
    .rd_mark  (rd_mark),
    .rd_hash  (rd_hash),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  // Output register: loads when empty or being drained this cycle
  assign res_take = res.valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= {res.count, res.value, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, out_data_r};

endmodule

// File: rtl/lpht_chk.sv
// ----------------------------------------------------------------------------
// lpht_chk
// Port-level checks for the hash table: reset clearing, busy after a
// request, output hold under stall and legal status codes.
// ----------------------------------------------------------------------------
module lpht_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lpht_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import lpht_pkg::*;

  // Clearing pass follows reset: no request taken right after it
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request accepted during mark clearing");

  // No request is taken right after another one
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready again right after a request transfer");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed or dropped under stall");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[STATUS_W-1:0] == ST_OK ||
                    out_tdata[STATUS_W-1:0] == ST_MISSING ||
                    out_tdata[STATUS_W-1:0] == ST_FULL))
    else $error("undefined status code on result");

endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (.*);

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for linear_probe_hash_table. A table of directed
// requests covers the empty table, all-zero and all-one fields, the unused
// opcode, updates, tombstones and missing keys. Random get/set/pop traffic on a
// small, colliding key pool follows, and a final fill phase drives the table
// into the full state. A software copy predicts each reply not fixed in the list. The
// request side sends in bursts with gaps. The reply side stalls in changing
// patterns and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import lpht_pkg::*;

  localparam int SLOTS        = DEF_TABLE_SLOTS;
  localparam int IN_W         = IN_TDATA_W;
  localparam int OUT_W        = OUT_TDATA_W;
  localparam int RANDOM_ITEMS = 760;
  localparam int POOL_SIZE    = 32;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = SLOTS + 40;
  localparam int CYCLE_LIMIT  = 1_500_000;

  // opcode with no function in the block
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   value;
    logic [COUNT_W-1:0]  count;
  } reply_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] hash;
    logic [WORD_W-1:0] wval;
    logic              typed;  // reply below is fixed, not predicted
    reply_t            want;
  } step_t;

  // Directed requests, in order; slot = hash[7:0]
  localparam int N_DIRECTED = 23;
  localparam step_t DIRECTED [N_DIRECTED] = '{
    '{OP_GET,  32'h0, 32'h0, 32'h0, 1'b1, '{ST_MISSING, 32'h0, 9'd0}},
    '{OP_POP,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b1, '{ST_MISSING, 32'h0, 9'd0}},
    '{OP_NONE, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'h0, 9'd0}},
    '{OP_SET,  32'h0, 32'h0, 32'hFFFFFFFF, 1'b1, '{ST_OK, 32'h0, 9'd1}},
    '{OP_GET,  32'h0, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'hFFFFFFFF, 9'd1}},
    '{OP_SET,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b1, '{ST_OK, 32'h0, 9'd2}},
    // same slot as key 0: lands one slot further
    '{OP_SET,  32'hFFFFFFFF, 32'h0, 32'h12345678, 1'b1, '{ST_OK, 32'h0, 9'd3}},
    // key present under another hash only
    '{OP_GET,  32'h0, 32'hFFFFFFFF, 32'h0, 1'b1, '{ST_MISSING, 32'h0, 9'd3}},
    '{OP_SET,  32'h0, 32'h0, 32'hAAAAAAAA, 1'b1, '{ST_OK, 32'h0, 9'd3}},
    '{OP_POP,  32'h0, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'hAAAAAAAA, 9'd2}},
    // probe walks over the tombstone
    '{OP_GET,  32'hFFFFFFFF, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'h12345678, 9'd2}},
    '{OP_POP,  32'h0, 32'h0, 32'h0, 1'b1, '{ST_MISSING, 32'h0, 9'd2}},
    // tombstone is not reused
    '{OP_SET,  32'h0, 32'h0, 32'h55555555, 1'b1, '{ST_OK, 32'h0, 9'd3}},
    '{OP_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{ST_OK, 32'h0, 9'd3}},
    '{OP_GET,  32'h0, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'h55555555, 9'd3}},
    '{OP_POP,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b1, '{ST_OK, 32'h0, 9'd2}},
    // wrap from the last slot into the cluster at the bottom
    '{OP_SET,  32'h5A5A5A5A, 32'h000000FF, 32'h00000001, 1'b0, '0},
    '{OP_SET,  32'hA5A5A5A5, 32'h100000FF, 32'h00000002, 1'b0, '0},
    '{OP_GET,  32'hA5A5A5A5, 32'h100000FF, 32'h0, 1'b0, '0},
    '{OP_SET,  32'h5A5A5A5A, 32'h000000FF, 32'hDEADBEEF, 1'b0, '0},
    '{OP_POP,  32'h5A5A5A5A, 32'h000000FF, 32'h0, 1'b0, '0},
    '{OP_GET,  32'h5A5A5A5A, 32'h000000FF, 32'h0, 1'b0, '0},
    '{OP_SET,  32'hC3C3C3C3, 32'h80000080, 32'h3C3C3C3C, 1'b0, '0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;    // opcode, key_word, key_hash, write_value
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;   // status, read_value, entry_count

  // Shadow copy of the table
  logic [MARK_W-1:0] shadow_mark  [SLOTS];
  logic [WORD_W-1:0] shadow_hash  [SLOTS];
  logic [WORD_W-1:0] shadow_key   [SLOTS];
  logic [WORD_W-1:0] shadow_value [SLOTS];
  int                shadow_live;

  reply_t pending_replies [$];
  reply_t oldest_reply;
  reply_t last_reply;
  int     mismatches;
  int     cycle_count;
  int     burst_left;
  bit     hold_request;

  logic [WORD_W-1:0] pool_key  [POOL_SIZE];
  logic [WORD_W-1:0] pool_hash [POOL_SIZE];

  linear_probe_hash_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 50 MHz clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Probe the shadow table, apply the request and return its reply
  function automatic reply_t lookup_and_update(input logic [OP_W-1:0] op,
                                               input logic [WORD_W-1:0] key,
                                               input logic [WORD_W-1:0] hash,
                                               input logic [WORD_W-1:0] wval);
    reply_t r;
    int     slot;
    int     visits;
    int     found;   // 1 match, 0 empty slot, -1 full wrap
    r = '0;
    r.status = ST_OK;
    found = -1;
    slot = int'(hash & (SLOTS - 1));
    if (op != OP_NONE) begin
      for (visits = 0; visits < SLOTS && found < 0; visits++) begin
        if (shadow_mark[slot] == MARK_EMPTY) begin
          found = 0;
        end else if (shadow_mark[slot] == MARK_LIVE && shadow_hash[slot] == hash &&
                     shadow_key[slot] == key) begin
          found = 1;
        end else begin
          slot = (slot + 1) % SLOTS;
        end
      end
      if (op == OP_SET) begin
        if (found == 1) begin
          shadow_value[slot] = wval;
        end else if (found == 0) begin
          shadow_mark[slot]  = MARK_LIVE;
          shadow_hash[slot]  = hash;
          shadow_key[slot]   = key;
          shadow_value[slot] = wval;
          shadow_live++;
        end else begin
          r.status = ST_FULL;
        end
      end else if (found == 1) begin
        r.value = shadow_value[slot];
        if (op == OP_POP) begin
          shadow_mark[slot] = MARK_TOMB;
          if (shadow_live > 0) shadow_live--;
        end
      end else begin
        r.status = ST_MISSING;
      end
    end
    r.count = shadow_live[COUNT_W-1:0];
    return r;
  endfunction

  // Offer one request in the current burst, wait for its transfer, then
  // queue the reply it should produce
  task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] key,
                              input logic [WORD_W-1:0] hash, input logic [WORD_W-1:0] wval,
                              input logic typed, input reply_t want);
    int     gap;
    reply_t predicted;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= IN_W'({$urandom, $urandom, $urandom, $urandom});
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({wval, hash, key, op});
    do @(posedge clk); while (!in_tready);
    predicted = lookup_and_update(op, key, hash, wval);
    last_reply = predicted;
    pending_replies.push_back(typed ? want : predicted);
  endtask

  task automatic refresh_pool_entry(input int idx);
    logic [WORD_W-1:0] h;
    h = $urandom;
    // keep most home slots in the low quarter so clusters form
    if ($urandom_range(0, 3) != 0) h[7:0] = 8'($urandom_range(0, 63));
    // some keys share a full hash with another key
    if (idx > 0 && $urandom_range(0, 7) == 0) h = pool_hash[idx - 1];
    pool_key[idx]  = $urandom;
    pool_hash[idx] = h;
  endtask

  // One random request, mostly on pool keys
  task automatic send_random_request();
    int idx;
    int pick;
    idx  = $urandom_range(0, POOL_SIZE - 1);
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) refresh_pool_entry(idx);
    if (pick < 35)
      send_request(OP_GET, pool_key[idx], pool_hash[idx], $urandom, 1'b0, '0);
    else if (pick < 73)
      send_request(OP_SET, pool_key[idx], pool_hash[idx], $urandom, 1'b0, '0);
    else if (pick < 93)
      send_request(OP_POP, pool_key[idx], pool_hash[idx], $urandom, 1'b0, '0);
    else if (pick < 96)
      send_request(OP_NONE, $urandom, $urandom, $urandom, 1'b0, '0);
    else if (pick < 98)
      // known key under a wrong hash
      send_request(2'($urandom_range(0, 2)), pool_key[idx], $urandom, $urandom, 1'b0, '0);
    else
      send_request(2'($urandom_range(0, 2)), $urandom, $urandom, $urandom, 1'b0, '0);
  endtask

  // Stimulus
  initial begin
    int i;
    int full_seen;
    int guard;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    shadow_live  = 0;
    mismatches   = 0;
    burst_left   = 0;
    hold_request = 1'b0;
    for (i = 0; i < SLOTS; i++) begin
      shadow_mark[i]  = MARK_EMPTY;
      shadow_hash[i]  = '0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
    end
    for (i = 0; i < POOL_SIZE; i++) refresh_pool_entry(i);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIRECTED; i++)
      send_request(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].hash, DIRECTED[i].wval,
                   DIRECTED[i].typed, DIRECTED[i].want);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) hold_request = 1'b1;
      send_random_request();
    end

    // Fresh keys until the table reports full a few times
    full_seen = 0;
    guard = 0;
    while (full_seen < 3 && guard < SLOTS + 16) begin
      send_request(OP_SET, $urandom, $urandom, $urandom, 1'b0, '0);
      if (last_reply.status == ST_FULL) full_seen++;
      guard++;
    end
    // Traffic on the full table, pops leave tombstones behind
    for (i = 0; i < 24; i++) send_random_request();

    @(negedge clk);
    in_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("linear_probe_hash_table: match");
    else
      $display("linear_probe_hash_table: mismatch");
    $finish;
  end

  // Reply side: stall pattern changes every stretch; one long hold-off
  initial begin
    int hold_left;
    int mode;
    int stretch;
    int phase;
    out_tready = 1'b0;
    hold_left  = 0;
    mode       = 0;
    stretch    = 0;
    phase      = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (stretch == 0) begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(50, 150);
      end
      stretch--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (phase % 4 == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each reply transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $error("reply transfer with nothing expected: status %0d value %h count %0d",
               out_tdata[1:0], out_tdata[33:2], out_tdata[42:34]);
        mismatches++;
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (out_tdata[1:0] !== oldest_reply.status) begin
          $error("status: expected %0d, got %0d", oldest_reply.status, out_tdata[1:0]);
          mismatches++;
        end
        if (out_tdata[33:2] !== oldest_reply.value) begin
          $error("read_value: expected %h, got %h", oldest_reply.value, out_tdata[33:2]);
          mismatches++;
        end
        if (out_tdata[42:34] !== oldest_reply.count) begin
          $error("entry_count: expected %0d, got %0d", oldest_reply.count, out_tdata[42:34]);
          mismatches++;
        end
      end
    end
  end

  // Hang guard
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("linear_probe_hash_table: mismatch");
      $finish;
    end
  end

endmodule
